/* design/midi_cc_learn_router_top_macros.svh */
// ---------------------------------------------------------------------------
// midi_cc_learn_router_top_macros
// Assertion macros for the learn router.
// ---------------------------------------------------------------------------
`ifndef MIDI_CC_LEARN_ROUTER_TOP_MACROS_SVH
`define MIDI_CC_LEARN_ROUTER_TOP_MACROS_SVH

// same-cycle implication
`define MCCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MCCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/mccl_pkg.sv */
// ---------------------------------------------------------------------------
// mccl_pkg
// Types and constants shared by the MIDI CC learn router.
// ---------------------------------------------------------------------------
package mccl_pkg;

   localparam int PARAM_COUNT = 7;
   localparam int MODE_COUNT  = 12;
   localparam int MATCH_COUNT = (PARAM_COUNT < 7) ? PARAM_COUNT : 7;
   localparam int TARGET_WIDTH = 3;

   localparam logic [2:0] CMD_CC       = 3'd0;
   localparam logic [2:0] CMD_PROGRAM  = 3'd1;
   localparam logic [2:0] CMD_REALTIME = 3'd2;
   localparam logic [2:0] CMD_LEARN    = 3'd3;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_UPDATE  = 3'd1;
   localparam logic [2:0] KIND_LEARNED = 3'd2;
   localparam logic [2:0] KIND_PROGRAM = 3'd3;
   localparam logic [2:0] KIND_TICK    = 3'd4;
   localparam logic [2:0] KIND_STOP    = 3'd5;

   localparam logic [7:0] RT_CLOCK = 8'hF8;
   localparam logic [7:0] RT_STOP  = 8'hFC;

   localparam logic [7:0] DEFAULT_CC [16] = '{
      8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21,
      8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29
   };

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_first;
      logic [6:0] data_second;
      logic [3:0] learn_slot;
   } req_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [6:0] match_mask;
      logic [6:0] cc_value;
      logic [3:0] program_number;
      logic       learn_pending;
   } rsp_type;

endpackage

/* design/midi_cc_learn_router_top.sv */
// ---------------------------------------------------------------------------
// midi_cc_learn_router_top
// MIDI event router with CC learn: input register, decode, result register.
// ---------------------------------------------------------------------------
//  channel | ports                              | moves
//  req     | req_valid req_ready req_payload    | one decoded MIDI event
//  rsp     | rsp_valid rsp_ready rsp_payload    | one result per event
//
// One transfer per cycle sustained while rsp is not stalled; a req passes the input
// register, the single decode pass and the result register before it reaches rsp.
// Reset clears both stages, the learn state and restores the default map.
// A stalled rsp holds the result; req keeps flowing while a stage is free.
// ---------------------------------------------------------------------------
`include "midi_cc_learn_router_top_macros.svh"

module midi_cc_learn_router_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mccl_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mccl_pkg::rsp_type rsp_payload
);
   import mccl_pkg::*;

   logic    in_vld_ff;
   req_type in_ff;
   logic    out_vld_ff;
   rsp_type out_ff;
   rsp_type core_rsp;
   logic    move;

   assign move      = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || move;
   assign rsp_valid = out_vld_ff;
   assign rsp_payload = out_ff;

   mccl_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (move),
      .item   (in_ff),
      .result (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ready) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (move) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_ff <= core_rsp;
      end
   end

   `MCCL_ASSERT_NEXT(a_move_shows, clock, reset, move, rsp_valid, "moved event not presented")

   `MCCL_ASSERT_NEXT(a_in_hold, clock, reset, in_vld_ff && !move, in_vld_ff && $stable(in_ff), "held event lost")

   `MCCL_ASSERT_NOW(a_update_fields, clock, reset, rsp_valid && rsp_payload.result_kind != KIND_UPDATE, rsp_payload.match_mask == '0 && rsp_payload.cc_value == '0, "update fields set on other kind")

   `MCCL_ASSERT_NOW(a_learned_clears, clock, reset, rsp_valid && rsp_payload.result_kind == KIND_LEARNED, !rsp_payload.learn_pending, "learn still armed after mapping")

endmodule

/* design/mccl_core.sv */
// ---------------------------------------------------------------------------
// mccl_core
// Slot map, learn state and combinational event decode.
// ---------------------------------------------------------------------------
module mccl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  mccl_pkg::req_type item,
   output mccl_pkg::rsp_type result
);
   import mccl_pkg::*;

   logic [7:0]              map_ff [PARAM_COUNT];
   logic [7:0]              map_in [PARAM_COUNT];
   logic                    armed_ff;
   logic                    armed_in;
   logic [TARGET_WIDTH-1:0] target_ff;
   logic [TARGET_WIDTH-1:0] target_in;
   logic [6:0]              hit;

   always_comb begin
      hit = '0;
      for (int i = 0; i < MATCH_COUNT; i++) begin
         hit[i] = (map_ff[i] == item.data_first);
      end
   end

   always_comb begin
      map_in    = map_ff;
      armed_in  = armed_ff;
      target_in = target_ff;
      result    = '0;
      case (item.command)
         CMD_CC: begin
            if (armed_ff) begin
               map_in[target_ff]  = item.data_first;
               armed_in           = 1'b0;
               target_in          = '0;
               result.result_kind = KIND_LEARNED;
            end else if (|hit) begin
               result.result_kind = KIND_UPDATE;
               result.match_mask  = hit;
               result.cc_value    = item.data_second;
            end
         end
         CMD_PROGRAM: begin
            if (item.data_first < 8'(MODE_COUNT)) begin
               result.result_kind    = KIND_PROGRAM;
               result.program_number = item.data_first[3:0];
            end
         end
         CMD_REALTIME: begin
            if (item.data_first == RT_CLOCK) begin
               result.result_kind = KIND_TICK;
            end else if (item.data_first == RT_STOP) begin
               result.result_kind = KIND_STOP;
            end
         end
         CMD_LEARN: begin
            if ({1'b0, item.learn_slot} < 5'(PARAM_COUNT)) begin
               armed_in  = 1'b1;
               target_in = item.learn_slot[TARGET_WIDTH-1:0];
            end else begin
               armed_in  = 1'b0;
               target_in = '0;
            end
         end
         default: begin
         end
      endcase
      result.learn_pending = armed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         target_ff <= '0;
         for (int i = 0; i < PARAM_COUNT; i++) begin
            map_ff[i] <= DEFAULT_CC[i % 16];
         end
      end else if (fire) begin
         armed_ff  <= armed_in;
         target_ff <= target_in;
         map_ff    <= map_in;
      end
   end

endmodule
